[design/mhpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Field widths, operation and status codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Fixed field widths of the channel beats
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Parameter defaults
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_KEY_BITS = 64;

    // Operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

[design/mhpq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_in_if / mhpq_out_if: request and response channels
// Valid/ready handshake; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface mhpq_in_if import mhpq_pkg::*;;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [KEY_W-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    key_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output key_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input key_out, input status, input occupancy,
                    output ready);
endinterface

[design/mhpq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram: heap key store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int   DEPTH = 16,
    parameter int   WIDTH = 64,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue: binary max-heap priority queue
// Insert / remove-maximum over a key store, one key comparator reused
// at every level of the sift.
// ----------------------------------------------------------------------------
// Usage
//   i_cmd carries one request per beat: kind 0 inserts key, kind 1 removes
//   the largest key. o_rsp returns exactly one beat per request: the removed
//   key (zero unless removed), a status code and the occupancy afterwards.
//   An insert into a full heap or a remove from an empty one reports
//   full / empty and leaves the heap untouched.
// Sequencing
//   One request at a time; i_cmd.ready is high only while the sequencer is
//   idle. Sift-up takes a parent read, then a compare and move, at each
//   level; sift-down a left read, a right read if there is a right child,
//   then a compare and move, all on the single store read port. A sift
//   moves at most log2(CAPACITY) levels; full or empty replies skip the
//   store and go straight to the response.
// Reset and stalls
//   Reset empties the heap (count to zero); the store itself is not
//   cleared, as only written entries are ever read. The response sits in an
//   output register; a new request is taken while it waits, and the next
//   result is held back until the receiver takes the old beat.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mhpq_in_if.sink       i_cmd,
    mhpq_out_if.source    o_rsp
);

    // Address of one entry, child index space, element count
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = AW + 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_BITS;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;       // current hole in the heap
    logic [KW-1:0]      r_key, n_key;       // key being sifted
    logic [KW-1:0]      r_best, n_best;     // larger of key and left child
    logic               r_lwin, n_lwin;     // left child beat the key
    logic [KW-1:0]      r_res_key, n_res_key;
    t_status            r_res_status, n_res_status;

    // Response register
    logic               r_o_valid;
    logic [KEY_W-1:0]   r_o_key;
    t_status            r_o_status;
    logic [OCC_W-1:0]   r_o_occ;
    logic               load_out;

    // Store port
    logic               we;
    logic [AW-1:0]      waddr;
    logic [KW-1:0]      wdata;
    logic [AW-1:0]      raddr;
    logic [KW-1:0]      rdata;

    // Index arithmetic
    logic [AW-1:0]      up_idx;
    logic [LW-1:0]      l_idx;
    logic [LW-1:0]      r_idx;
    logic [LW-1:0]      cnt_ext;

    // Shared key comparator
    logic [KW-1:0]      cmp_a;
    logic [KW-1:0]      cmp_b;
    logic               cmp_gt;

    assign up_idx  = AW'((r_pos - AW'(1)) >> 1);
    assign l_idx   = {r_pos, 1'b1};
    assign r_idx   = l_idx + LW'(1);
    assign cnt_ext = LW'(r_count);

    // Sift-up asks "parent < key", sift-down "child > key / best"
    always_comb begin
        if (r_state == S_UP_CMP) begin
            cmp_a = r_key;
            cmp_b = rdata;
        end else begin
            cmp_a = rdata;
            cmp_b = (r_state == S_DN_CMP) ? r_best : r_key;
        end
    end

    assign cmp_gt = (cmp_a > cmp_b);

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_best       <= n_best;
        r_lwin       <= n_lwin;
        r_res_key    <= n_res_key;
        r_res_status <= n_res_status;
    end

    // Sequencer: holes move instead of swapping, the sifted key is written
    // once at its final place.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_key        = r_key;
        n_best       = r_best;
        n_lwin       = r_lwin;
        n_res_key    = r_res_key;
        n_res_status = r_res_status;
        we           = 1'b0;
        waddr        = r_pos;
        wdata        = r_key;
        raddr        = '0;
        load_out     = 1'b0;
        i_cmd.ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_res_key = '0;
                    if (i_cmd.kind == KIND_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_key        = KW'(i_cmd.key);
                            n_pos        = AW'(r_count);
                            n_count      = r_count + CW'(1);
                            n_res_status = ST_INSERTED;
                            n_state      = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            raddr        = '0;
                            n_res_status = ST_REMOVED;
                            n_state      = S_RM_ROOT;
                        end
                    end
                end
            end

            S_UP_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    raddr   = up_idx;
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                we = 1'b1;
                if (cmp_gt) begin
                    // parent smaller: pull it down into the hole
                    wdata   = rdata;
                    n_pos   = up_idx;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_RM_ROOT: begin
                n_res_key = rdata;
                raddr     = AW'(r_count - CW'(1));
                n_count   = r_count - CW'(1);
                n_state   = S_RM_LAST;
            end

            S_RM_LAST: begin
                n_key   = rdata;
                n_pos   = '0;
                n_state = S_DN_L;
            end

            S_DN_L: begin
                if (l_idx < cnt_ext) begin
                    raddr   = AW'(l_idx);
                    n_state = S_DN_R;
                end else begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DN_R: begin
                n_lwin = cmp_gt;
                n_best = cmp_gt ? rdata : r_key;
                if (r_idx < cnt_ext) begin
                    raddr   = AW'(r_idx);
                    n_state = S_DN_CMP;
                end else begin
                    // left child only
                    we = 1'b1;
                    if (cmp_gt) begin
                        wdata   = rdata;
                        n_pos   = AW'(l_idx);
                        n_state = S_DN_L;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DN_CMP: begin
                we = 1'b1;
                if (cmp_gt) begin
                    wdata   = rdata;
                    n_pos   = AW'(r_idx);
                    n_state = S_DN_L;
                end else if (r_lwin) begin
                    wdata   = r_best;
                    n_pos   = AW'(l_idx);
                    n_state = S_DN_L;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_key    <= KEY_W'(r_res_key);
            r_o_status <= r_res_status;
            r_o_occ    <= OCC_W'(r_count);
        end
    end

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.key_out   = r_o_key;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.occupancy = r_o_occ;

endmodule
